FILE: design/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and codes for the priority/time event store.
// ----------------------------------------------------------------------------
package pte_pkg;

    // Operation codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // A key orders by priority first and then by timestamp.
    typedef struct packed {
        logic [1:0]  pri;
        logic [31:0] tim;
    } t_key;

    // One stored slot word: key and payload handle.
    typedef struct packed {
        t_key        key;
        logic [31:0] value;
    } t_entry;

    // Outcome of one pass of the shared key comparator.
    typedef struct packed {
        logic eq_a;
        logic lt_a;
        logic gt_b;
    } t_cmp;

endpackage

FILE: design/priority_time_event_store.sv
// ----------------------------------------------------------------------------
// priority_time_event_store
// Keyed event table ordered by priority, then timestamp, with insert, find
// and remove, reporting lowest and highest entries after every operation.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Beat contents
//  -------   ---------------------   ------------------------------------------
//  in        i_in_valid/o_in_stall   mode, event_priority, event_time, value
//  out       o_out_valid/i_out_stall status, found, lowest, highest, empty, count
//
// Each item runs a match scan and an extremes sweep, and each pass walks
// all DEPTH slots through the single read port of the slot memory and the one
// shared key comparator; accept, update and result steps come around them.
// Reset clears the valid bits and the count at once; slot words need no clear.
// A result waiting under stall holds the sequencer before its output load, and
// the next item is taken as soon as the sequencer is back to idle.
// ----------------------------------------------------------------------------
module priority_time_event_store
    import pte_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_event_priority,
    input  logic [31:0] i_event_time,
    input  logic [31:0] i_event_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [31:0] o_lowest_value,
    output logic [31:0] o_highest_value,
    output logic        o_is_empty,
    output logic [4:0]  o_entry_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_APPLY  = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Latched request.
    logic [1:0]  r_mode;
    t_key        r_req_key;
    logic [31:0] r_req_value;

    // Table state held in flops.
    logic [DEPTH-1:0] r_valid;
    logic [CW-1:0]    r_count;

    // Walk control shared by both passes.
    logic [IW-1:0] r_addr;
    logic          r_issue_done;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_live;

    // Match scan results.
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_value;
    logic          r_free_ok;
    logic [IW-1:0] r_free_idx;

    // Extremes sweep results.
    logic   r_ext_ok;
    t_entry r_lo;
    t_entry r_hi;

    // Operation outcome.
    logic [1:0]  r_status;
    logic [31:0] r_found;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_found;
    logic [31:0] r_out_low;
    logic [31:0] r_out_high;
    logic        r_out_empty;
    logic [4:0]  r_out_count;

    // Memory and comparator hookup.
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    t_entry        mem_wr_data;
    t_entry        mem_rd_data;
    t_key          cmp_ref_a;
    t_key          cmp_ref_b;
    t_cmp          cmp;

    logic in_beat;
    logic out_free;
    logic slot_live;
    logic walk_end;

    assign in_beat   = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign slot_live = r_rd_live && r_valid[r_rd_idx];
    assign walk_end  = r_rd_live && (r_rd_idx == LAST);

    pte_slot_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_rd_data)
    );

    // The comparator checks the request key in the scan, the extremes in the sweep.
    assign cmp_ref_a = (r_state == ST_SCAN) ? r_req_key : r_lo.key;
    assign cmp_ref_b = r_hi.key;

    pte_key_cmp u_cmp (
        .i_slot_key (mem_rd_data.key),
        .i_ref_a    (cmp_ref_a),
        .i_ref_b    (cmp_ref_b),
        .o_cmp      (cmp)
    );

    // Slot write for an insert, either over the hit slot or into the free slot.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_hit ? r_hit_idx : r_free_idx;
        mem_wr_data = '{key: r_req_key, value: r_req_value};
        if ((r_state == ST_APPLY) && (r_mode == MODE_INSERT) && (r_hit || r_free_ok)) begin
            mem_wr_en = 1'b1;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_beat) n_state = ST_SCAN;
            ST_SCAN:   if (walk_end) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_SWEEP;
            ST_SWEEP:  if (walk_end) n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode      <= i_mode;
            r_req_key   <= '{pri: i_event_priority, tim: i_event_time};
            r_req_value <= i_event_value;
        end
    end

    // Address walk: issue one read a cycle, then follow it with its index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_idx     <= '0;
            r_rd_live    <= 1'b0;
        end else if (in_beat || (r_state == ST_APPLY)) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_live    <= 1'b0;
        end else if ((r_state == ST_SCAN) || (r_state == ST_SWEEP)) begin
            r_rd_idx  <= r_addr;
            r_rd_live <= !r_issue_done;
            if (!r_issue_done) begin
                if (r_addr == LAST) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (walk_end) begin
                r_rd_live <= 1'b0;
            end
        end
    end

    // Match scan: first slot holding the key and lowest free slot.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (slot_live && cmp.eq_a && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_value <= mem_rd_data.value;
            end
            if (r_rd_live && !r_valid[r_rd_idx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // Table update, status and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (r_state == ST_APPLY) begin
            case (r_mode)
                MODE_INSERT: begin
                    if (!r_hit && r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_count             <= r_count + 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (r_hit) begin
                        r_valid[r_hit_idx] <= 1'b0;
                        if (r_count != '0) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY) begin
            r_status <= STATUS_OK;
            r_found  <= '0;
            case (r_mode)
                MODE_INSERT: begin
                    if (!r_hit && !r_free_ok) r_status <= STATUS_FULL;
                end
                MODE_FIND: begin
                    if (r_hit) r_found  <= r_hit_value;
                    else       r_status <= STATUS_NOT_FOUND;
                end
                MODE_REMOVE: begin
                    if (!r_hit) r_status <= STATUS_NOT_FOUND;
                end
                default: begin
                end
            endcase
        end
    end

    // Extremes sweep over the valid slots after the update.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY) begin
            r_ext_ok <= 1'b0;
        end else if ((r_state == ST_SWEEP) && slot_live) begin
            if (!r_ext_ok) begin
                r_ext_ok <= 1'b1;
                r_lo     <= mem_rd_data;
                r_hi     <= mem_rd_data;
            end else begin
                if (cmp.lt_a) r_lo <= mem_rd_data;
                if (cmp.gt_b) r_hi <= mem_rd_data;
            end
        end
    end

    // Output register: a finished result is loaded once the last one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && out_free) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_low    <= r_ext_ok ? r_lo.value : 32'd0;
            r_out_high   <= r_ext_ok ? r_hi.value : 32'd0;
            r_out_empty  <= (r_count == '0);
            r_out_count  <= 5'(r_count);
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found_value   = r_out_found;
    assign o_lowest_value  = r_out_low;
    assign o_highest_value = r_out_high;
    assign o_is_empty      = r_out_empty;
    assign o_entry_count   = r_out_count;

endmodule

FILE: design/pte_key_cmp.sv
// ----------------------------------------------------------------------------
// pte_key_cmp
// Shared key comparator: tests one slot key against two reference keys.
// ----------------------------------------------------------------------------
module pte_key_cmp
    import pte_pkg::*;
(
    input  t_key i_slot_key,
    input  t_key i_ref_a,
    input  t_key i_ref_b,
    output t_cmp o_cmp
);

    // The packed key compares as one unsigned number, priority in the top bits.
    assign o_cmp.eq_a = (i_slot_key == i_ref_a);
    assign o_cmp.lt_a = (i_slot_key <  i_ref_a);
    assign o_cmp.gt_b = (i_slot_key >  i_ref_b);

endmodule

FILE: design/pte_slot_mem.sv
// ----------------------------------------------------------------------------
// pte_slot_mem
// Slot storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pte_slot_mem
    import pte_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write and read share one clocked block; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
